### design/bcs_pkg.sv
package bcs_pkg;

    localparam int PIPE_DEPTH = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd2;

    localparam logic [17:0] Q_ONE = 18'd65536;
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam int RECIP_SHIFT = 22;

    typedef logic [7:0] chan_t;

    typedef struct packed {
        logic signed [8:0] adj;
        logic [17:0]       sat;
        logic [17:0]       gain;
    } coef_t;

    function automatic logic signed [7:0] clamp_level(input logic [7:0] raw);
        logic signed [7:0] v;
        v = $signed(raw);
        if (v < -8'sd100)
            return -8'sd100;
        else if (v > 8'sd100)
            return 8'sd100;
        else
            return v;
    endfunction

    // Exact quotient by 100 for any dividend up to 25599, by reciprocal multiplication.
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(RECIP_100);
        return p[RECIP_SHIFT +: 8];
    endfunction

    function automatic logic signed [8:0] bright_offset(input logic [7:0] raw);
        logic signed [7:0] lvl;
        logic [6:0]        mag;
        logic [7:0]        q;
        lvl = clamp_level(raw);
        mag = (lvl < 0) ? 7'(-lvl) : 7'(lvl);
        q = div100(15'(mag) * 15'd255);
        if (lvl < 0)
            return -$signed({1'b0, q});
        else
            return $signed({1'b0, q});
    endfunction

    // (level + 100) * 65536 / 100, split as 655 * y + (36 * y) / 100.
    function automatic logic [17:0] sat_gain(input logic [7:0] raw);
        logic signed [7:0] lvl;
        logic [8:0]        yy;
        logic [7:0]        y;
        lvl = clamp_level(raw);
        yy = 9'($signed({lvl[7], lvl}) + 9'sd100);
        y = yy[7:0];
        return (18'(y) * 18'd655) + 18'(div100(15'(y) * 15'd36));
    endfunction

    function automatic chan_t clamp_u8(input logic signed [9:0] s);
        if (s < 0)
            return 8'd0;
        else if (s > 10'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

    function automatic chan_t q16_pix(input logic signed [27:0] v);
        if (v < 0)
            return 8'd0;
        else if (v[27:16] > 12'd255)
            return 8'd255;
        else
            return v[23:16];
    endfunction

endpackage

### design/bcs_if.sv
interface bcs_in_if;
    logic  valid;
    logic  ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  input in_alpha, output ready);
endinterface

interface bcs_out_if;
    logic  valid;
    logic  ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, output ready);
endinterface

interface bcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/bcs_cfg.sv
module bcs_cfg (
    input  logic            clk,
    input  logic            rst_n,
    bcs_cfg_if.sink         cfg,
    output bcs_pkg::coef_t  coef,
    output logic            busy
);

    logic signed [8:0]               adj_reg, adj_next;
    logic [17:0]                     sat_reg, sat_next;
    logic [17:0]                     gain_reg, gain_next;
    logic                            busy_reg, busy_next;
    logic [bcs_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [32:0]                     num_reg, num_next;
    logic [16:0]                     den_reg, den_next;
    logic [16:0]                     rem_reg, rem_next;

    logic                            wr;
    logic signed [7:0]               lvl;
    logic [8:0]                      cp;
    logic [9:0]                      dd;
    logic [16:0]                     num_hi;
    logic [17:0]                     shifted;
    logic                            ge;

    assign wr = cfg.valid && cfg.ready;
    assign cfg.ready = !busy_reg;
    assign busy = busy_reg;
    assign coef = '{adj: adj_reg, sat: sat_reg, gain: gain_reg};

    always_comb
    begin
        lvl = bcs_pkg::clamp_level(cfg.data);
        cp = 9'($signed({lvl[7], lvl}) + 9'sd255);
        dd = 10'(10'sd259 - $signed({{2{lvl[7]}}, lvl}));
        num_hi = 17'(cp) * 17'd259;

        shifted = {1'b0, rem_reg[15:0], num_reg[32]};
        shifted[17] = rem_reg[16];
        ge = shifted >= {1'b0, den_reg};

        adj_next = adj_reg;
        sat_next = sat_reg;
        gain_next = gain_reg;
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;

        if (busy_reg)
        begin
            rem_next = ge ? 17'(shifted - {1'b0, den_reg}) : shifted[16:0];
            num_next = {num_reg[31:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bcs_pkg::DIV_CNT_W'(1))
            begin
                gain_next = num_next[17:0];
                busy_next = 1'b0;
            end
        end
        else if (wr)
        begin
            unique case (cfg.index)
                bcs_pkg::REG_BRIGHTNESS:
                begin
                    adj_next = bcs_pkg::bright_offset(cfg.data);
                end
                bcs_pkg::REG_CONTRAST:
                begin
                    num_next = {num_hi, 16'd0};
                    den_next = 17'(dd[8:0]) * 17'd255;
                    rem_next = '0;
                    cnt_next = bcs_pkg::DIV_CNT_W'(bcs_pkg::DIV_STEPS);
                    busy_next = 1'b1;
                end
                bcs_pkg::REG_SATURATION:
                begin
                    sat_next = bcs_pkg::sat_gain(cfg.data);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= '0;
            sat_reg <= bcs_pkg::Q_ONE;
            gain_reg <= bcs_pkg::Q_ONE;
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            adj_reg <= adj_next;
            sat_reg <= sat_next;
            gain_reg <= gain_next;
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

### design/bcs_pipe.sv
module bcs_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  bcs_pkg::coef_t  coef,
    input  logic            hold,
    bcs_in_if.sink          pixel,
    bcs_out_if.source       adjusted
);

    localparam int N = bcs_pkg::PIPE_DEPTH;

    logic [N-1:0]       vld_reg, vld_next;
    logic [N-1:0]       en;
    logic               take;

    bcs_pkg::chan_t     alpha_reg [N];

    bcs_pkg::chan_t     s1_ch_reg [3], s1_ch_next [3];
    logic signed [27:0] s2_prod_reg [3], s2_prod_next [3];
    bcs_pkg::chan_t     s3_ch_reg [3], s3_ch_next [3];
    logic [23:0]        s4_wp_reg [3], s4_wp_next [3];
    bcs_pkg::chan_t     s4_ch_reg [3];
    bcs_pkg::chan_t     s5_luma_reg, s5_luma_next;
    bcs_pkg::chan_t     s5_ch_reg [3];
    logic signed [27:0] s6_prod_reg [3], s6_prod_next [3];
    bcs_pkg::chan_t     s6_luma_reg;
    bcs_pkg::chan_t     s7_ch_reg [3], s7_ch_next [3];

    bcs_pkg::chan_t     in_ch [3];
    logic [15:0]        luma_w [3];
    logic [24:0]        luma_sum;

    assign in_ch[0] = pixel.in_red;
    assign in_ch[1] = pixel.in_green;
    assign in_ch[2] = pixel.in_blue;
    assign luma_w[0] = bcs_pkg::LUMA_WR;
    assign luma_w[1] = bcs_pkg::LUMA_WG;
    assign luma_w[2] = bcs_pkg::LUMA_WB;

    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || adjusted.ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign pixel.ready = en[0] && !hold;
    assign take = pixel.valid && pixel.ready;

    always_comb
    begin
        vld_next[0] = en[0] ? take : vld_reg[0];
        for (int i = 1; i < N; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_comb
    begin
        luma_sum = 25'(s4_wp_reg[0]) + 25'(s4_wp_reg[1]) + 25'(s4_wp_reg[2]);
        s5_luma_next = luma_sum[23:16];
        for (int c = 0; c < 3; c++)
        begin
            s1_ch_next[c] = bcs_pkg::clamp_u8($signed({2'b00, in_ch[c]})
                                              + $signed({coef.adj[8], coef.adj}));
            s2_prod_next[c] = 28'($signed({1'b0, coef.gain})
                                  * ($signed({1'b0, s1_ch_reg[c]}) - 9'sd128));
            s3_ch_next[c] = bcs_pkg::q16_pix(s2_prod_reg[c] + 28'sd8388608);
            s4_wp_next[c] = 24'(s3_ch_reg[c]) * 24'(luma_w[c]);
            s6_prod_next[c] = 28'($signed({1'b0, coef.sat})
                                  * ($signed({1'b0, s5_ch_reg[c]})
                                     - $signed({1'b0, s5_luma_reg})));
            s7_ch_next[c] = bcs_pkg::q16_pix($signed({4'b0000, s6_luma_reg, 16'd0})
                                             + s6_prod_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            alpha_reg[0] <= pixel.in_alpha;
            s1_ch_reg <= s1_ch_next;
        end
        if (en[1])
        begin
            s2_prod_reg <= s2_prod_next;
        end
        if (en[2])
        begin
            s3_ch_reg <= s3_ch_next;
        end
        if (en[3])
        begin
            s4_wp_reg <= s4_wp_next;
            s4_ch_reg <= s3_ch_reg;
        end
        if (en[4])
        begin
            s5_luma_reg <= s5_luma_next;
            s5_ch_reg <= s4_ch_reg;
        end
        if (en[5])
        begin
            s6_prod_reg <= s6_prod_next;
            s6_luma_reg <= s5_luma_reg;
        end
        if (en[6])
        begin
            s7_ch_reg <= s7_ch_next;
        end
        for (int i = 1; i < N; i++)
        begin
            if (en[i])
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    assign adjusted.valid = vld_reg[N-1];
    assign adjusted.out_red = s7_ch_reg[0];
    assign adjusted.out_green = s7_ch_reg[1];
    assign adjusted.out_blue = s7_ch_reg[2];
    assign adjusted.out_alpha = alpha_reg[N-1];

endmodule

### design/pixel_brightness_contrast_saturation_core.sv
// Brightness, contrast and saturation adjustment of ARGB8888 pixels.
// The pixel channel takes one word per clock while pixel ready is high (valid/ready)
// with the red, green, blue and alpha bytes; the adjusted channel returns one word per
// input word, in order, with alpha copied unchanged.
// The cfg channel writes register 0 (brightness), 1 (contrast) or 2 (saturation);
// other indexes are accepted and ignored. Levels outside -100..100 are saturated.
// A contrast write starts a serial divide that forms the contrast gain;
// cfg and pixel ready stay low until it finishes. Other writes leave cfg ready high.
// Adjusted valid rises once the pixel has passed through every register of the
// seven-stage pipeline; throughput is one pixel per clock while adjusted ready is
// high and no contrast divide is running.
// When the receiver stalls, each stage holds its word and empty stages still fill,
// so pixel ready drops only once all seven stages hold words.
// Reset clears the pipeline, sets all levels to zero and the gains to unity.
module pixel_brightness_contrast_saturation_core (
    input  logic        clk,
    input  logic        rst_n,
    bcs_cfg_if.sink     cfg,
    bcs_in_if.sink      pixel,
    bcs_out_if.source   adjusted
);

    bcs_pkg::coef_t coef;
    logic           busy;

    bcs_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef),
        .busy  (busy)
    );

    bcs_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .hold     (busy),
        .pixel    (pixel),
        .adjusted (adjusted)
    );

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS = 65;
    localparam int HOLD_CYCLES = 60;

    localparam logic [7:0] TABLE_BRIGHT [4] = '{8'd0, 8'hCE, 8'd100, 8'd30};
    localparam logic [7:0] TABLE_CONTRAST [4] = '{8'h7F, 8'd50, 8'h9C, 8'd100};
    localparam logic [7:0] TABLE_SATURATION [4] = '{8'h81, 8'd100, 8'd0, 8'h9C};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    logic clk;
    logic rst_n;

    bcs_cfg_if cfg_if ();
    bcs_in_if pixel_if ();
    bcs_out_if adjusted_if ();

    pixel_brightness_contrast_saturation_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .pixel    (pixel_if),
        .adjusted (adjusted_if)
    );

    // Local copy of the adjustment settings.
    logic [7:0]  bright_level_raw = 8'd0;
    logic [7:0]  sat_level_raw = 8'd0;
    logic [17:0] contrast_gain_q16 = 18'd65536;

    pixel_t pending_pixels [$];
    pixel_t expected_pixels [$];

    int pix_loaded = 0;
    int pix_offered = 0;
    int pix_accepted = 0;
    int pix_returned = 0;
    int error_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int level_of(logic [7:0] raw);
        int v;
        v = $signed(raw);
        if (v < -100)
            v = -100;
        if (v > 100)
            v = 100;
        return v;
    endfunction

    function automatic logic [17:0] contrast_gain_of(int c);
        longint num;
        longint den;
        num = longint'(259 * (c + 255)) * 65536;
        den = 255 * (259 - c);
        return 18'(num / den);
    endfunction

    function automatic int q16_to_chan(longint x);
        if (x < 0)
            return 0;
        x = x >>> 16;
        if (x > 255)
            return 255;
        return int'(x);
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t px);
        int     offset;
        int     luma;
        int     i;
        int     ch [3];
        longint sat_q16;
        longint gain;
        pixel_t res;
        offset = level_of(bright_level_raw) * 255 / 100;
        sat_q16 = (level_of(sat_level_raw) + 100) * 65536 / 100;
        gain = contrast_gain_q16;
        ch[0] = px.red;
        ch[1] = px.green;
        ch[2] = px.blue;
        for (i = 0; i < 3; i++)
        begin
            ch[i] = ch[i] + offset;
            if (ch[i] < 0)
                ch[i] = 0;
            if (ch[i] > 255)
                ch[i] = 255;
        end
        for (i = 0; i < 3; i++)
            ch[i] = q16_to_chan(gain * (ch[i] - 128) + longint'(128) * 65536);
        luma = (19595 * ch[0] + 38470 * ch[1] + 7471 * ch[2]) >>> 16;
        for (i = 0; i < 3; i++)
            ch[i] = q16_to_chan(longint'(luma) * 65536 + sat_q16 * (ch[i] - luma));
        res.red = ch[0][7:0];
        res.green = ch[1][7:0];
        res.blue = ch[2][7:0];
        res.alpha = px.alpha;
        return res;
    endfunction

    function automatic logic [7:0] random_channel();
        if ($urandom_range(99) < 15)
            return $urandom_range(1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] random_level();
        if ($urandom_range(1) == 1)
            return 8'($urandom);
        return 8'(int'($urandom_range(200)) - 100);
    endfunction

    task automatic load_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.alpha = a;
        pending_pixels.push_back(px);
        pix_loaded++;
    endtask

    task automatic write_reg(logic [bcs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            bcs_pkg::REG_BRIGHTNESS: bright_level_raw = value;
            bcs_pkg::REG_CONTRAST:   contrast_gain_q16 = contrast_gain_of(level_of(value));
            bcs_pkg::REG_SATURATION: sat_level_raw = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every loaded pixel has come back, then lets the pipeline empty.
    task automatic settle();
        while (pix_accepted != pix_loaded || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (bcs_pkg::PIPE_DEPTH + 2)
            @(posedge clk);
    endtask

    task automatic compare_channel(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        pixel_t nxt;
        if (pix_accepted == pix_offered)
        begin
            if (pending_pixels.size() != 0
                && ((pix_offered >= 420 && pix_offered < 540) || $urandom_range(99) >= 10))
            begin
                nxt = pending_pixels.pop_front();
                pixel_if.valid <= 1'b1;
                pixel_if.in_red <= nxt.red;
                pixel_if.in_green <= nxt.green;
                pixel_if.in_blue <= nxt.blue;
                pixel_if.in_alpha <= nxt.alpha;
                pix_offered++;
            end
            else
                pixel_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            adjusted_if.ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && pix_returned >= 300)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            adjusted_if.ready <= 1'b0;
        end
        else
            adjusted_if.ready <= (pix_returned >= 415 && pix_returned < 535)
                                 || $urandom_range(99) >= 10;
    end

    always @(posedge clk)
    begin
        pixel_t px;
        pixel_t got;
        pixel_t want;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            px.red = pixel_if.in_red;
            px.green = pixel_if.in_green;
            px.blue = pixel_if.in_blue;
            px.alpha = pixel_if.in_alpha;
            expected_pixels.push_back(adjust_pixel(px));
            pix_accepted++;
        end
        if (rst_n && adjusted_if.valid && adjusted_if.ready)
        begin
            got.red = adjusted_if.out_red;
            got.green = adjusted_if.out_green;
            got.blue = adjusted_if.out_blue;
            got.alpha = adjusted_if.out_alpha;
            if (expected_pixels.size() == 0)
            begin
                $error("adjusted word with no pixel pending");
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_channel("out_red", want.red, got.red);
                compare_channel("out_green", want.green, got.green);
                compare_channel("out_blue", want.blue, got.blue);
                compare_channel("out_alpha", want.alpha, got.alpha);
            end
            pix_returned++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        pixel_if.valid = 1'b0;
        pixel_if.in_red = '0;
        pixel_if.in_green = '0;
        pixel_if.in_blue = '0;
        pixel_if.in_alpha = '0;
        adjusted_if.ready = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        load_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        load_pixel(8'd128, 8'd128, 8'd128, 8'd128);
        load_pixel(8'd255, 8'd0, 8'd0, 8'hAA);
        load_pixel(8'd0, 8'd255, 8'd0, 8'h55);
        load_pixel(8'd0, 8'd0, 8'd255, 8'd1);

        settle();
        write_reg(bcs_pkg::REG_BRIGHTNESS, 8'd100);
        load_pixel(8'd0, 8'd0, 8'd0, 8'd9);
        load_pixel(8'd100, 8'd200, 8'd30, 8'd250);

        settle();
        write_reg(bcs_pkg::REG_BRIGHTNESS, 8'h80);
        load_pixel(8'd255, 8'd255, 8'd255, 8'd9);
        load_pixel(8'd100, 8'd200, 8'd30, 8'd250);

        settle();
        write_reg(bcs_pkg::REG_BRIGHTNESS, 8'd0);
        write_reg(bcs_pkg::REG_CONTRAST, 8'd100);
        write_reg(bcs_pkg::REG_SATURATION, 8'd100);
        load_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        load_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        load_pixel(8'd128, 8'd100, 8'd160, 8'd3);
        load_pixel(8'd20, 8'd240, 8'd120, 8'd200);

        settle();
        write_reg(bcs_pkg::REG_CONTRAST, 8'h80);
        write_reg(bcs_pkg::REG_SATURATION, 8'h80);
        write_reg(REG_UNUSED, 8'h55);
        write_reg(bcs_pkg::REG_BRIGHTNESS, 8'd20);
        load_pixel(8'd0, 8'd255, 8'd128, 8'd0);
        load_pixel(8'd64, 8'd192, 8'd32, 8'd255);
        load_pixel(8'd255, 8'd0, 8'd0, 8'd1);
        load_pixel(8'd90, 8'd90, 8'd200, 8'd77);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase < 4)
            begin
                write_reg(bcs_pkg::REG_BRIGHTNESS, TABLE_BRIGHT[phase]);
                write_reg(bcs_pkg::REG_CONTRAST, TABLE_CONTRAST[phase]);
                write_reg(bcs_pkg::REG_SATURATION, TABLE_SATURATION[phase]);
            end
            else
            begin
                if ($urandom_range(9) < 7)
                    write_reg(bcs_pkg::REG_BRIGHTNESS, random_level());
                if ($urandom_range(9) < 7)
                    write_reg(bcs_pkg::REG_CONTRAST, random_level());
                if ($urandom_range(9) < 7)
                    write_reg(bcs_pkg::REG_SATURATION, random_level());
                if ($urandom_range(4) == 0)
                    write_reg(REG_UNUSED, 8'($urandom));
            end
            for (n = 0; n < PHASE_PIXELS; n++)
                load_pixel(random_channel(), random_channel(), random_channel(),
                           8'($urandom));
        end

        settle();
        repeat (4 * bcs_pkg::PIPE_DEPTH)
            @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
